>>> design/dss_pkg.sv
// shared types and constants for the door swing settle detector
// no dependencies; used by the interfaces and the top level

package dss_pkg;

    localparam int PITCH_BITS = 16;
    localparam int RATE_BITS  = 16;
    localparam int LIMIT_BITS = 15;
    localparam int AMP_BITS   = 15;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_OPEN_PITCH_LIMIT        = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOSED_PITCH_LIMIT      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXTREMUM_RATE_THRESHOLD = 2'd2;

    localparam logic [LIMIT_BITS-1:0] OPEN_PITCH_LIMIT_RESET        = 15'd1280;
    localparam logic [LIMIT_BITS-1:0] CLOSED_PITCH_LIMIT_RESET      = 15'd154;
    localparam logic [LIMIT_BITS-1:0] EXTREMUM_RATE_THRESHOLD_RESET = 15'd128;

    localparam logic [AMP_BITS-1:0] AMP_MAX = '1;

    typedef enum logic [1:0] {
        ST_NO_SAMPLE = 2'd0,
        ST_DETECTING = 2'd1,
        ST_OPEN      = 2'd2,
        ST_CLOSED    = 2'd3
    } door_state_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_PEAK   = 2'd1,
        KIND_TROUGH = 2'd2
    } kind_t;

    typedef struct packed {
        logic                         sample_ready;
        logic signed [PITCH_BITS-1:0] pitch_angle;
        logic signed [RATE_BITS-1:0]  rate_x;
        logic                         gyro_moving;
        logic                         accel_moving;
    } sample_t;

endpackage

>>> design/dss_sample_if.sv
// valid/ready channel carrying one fused imu sample
// depends on dss_pkg for field widths

interface dss_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  sample_ready;
    logic signed [dss_pkg::PITCH_BITS-1:0] pitch_angle;
    logic signed [dss_pkg::RATE_BITS-1:0]  rate_x;
    logic                                  gyro_moving;
    logic                                  accel_moving;

    modport source (
        output valid, sample_ready, pitch_angle, rate_x, gyro_moving, accel_moving,
        input  ready
    );
    modport sink (
        input  valid, sample_ready, pitch_angle, rate_x, gyro_moving, accel_moving,
        output ready
    );
endinterface

>>> design/dss_state_if.sv
// valid/ready channel carrying one door state result
// depends on dss_pkg for the result type

interface dss_state_if;
    logic                 valid;
    logic                 ready;
    dss_pkg::door_state_t door_state;

    modport source (output valid, door_state, input ready);
    modport sink   (input valid, door_state, output ready);
endinterface

>>> design/door_swing_settle_detector.sv
// door swing settle detector top level: input register, update logic, result register
// depends on dss_pkg, dss_sample_if and dss_state_if

// Takes one fused imu sample per transaction and returns one door state per sample,
// sustaining one sample per clock cycle while result_out.ready stays high. Each
// sample passes an input register and a result register, which stall while a result
// is not taken; the swing tracking state is updated in the same cycle the result
// register is loaded, so the following sample uses it right away. Samples without
// sample_ready return the no-sample state and leave all state untouched. The user
// must write limits through the cfg port only while the block is idle; the block
// does not enforce it. COUNT_BITS sizes the saturating alternation and decay counters.
module door_swing_settle_detector #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [dss_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [dss_pkg::LIMIT_BITS-1:0]            cfg_data,
    dss_sample_if.sink                                sample_in,
    dss_state_if.source                               result_out
);

    // configuration
    logic [dss_pkg::LIMIT_BITS-1:0] open_pitch_limit_reg;
    logic [dss_pkg::LIMIT_BITS-1:0] closed_pitch_limit_reg;
    logic [dss_pkg::LIMIT_BITS-1:0] extremum_rate_threshold_reg;

    // pipeline
    logic                 in_valid_reg;
    dss_pkg::sample_t     in_sample_reg;
    logic                 out_valid_reg;
    dss_pkg::door_state_t out_state_reg;
    dss_pkg::door_state_t out_state_next;
    logic                 out_free;
    logic                 s1_advance;
    logic                 in_take;

    // tracking state
    logic signed [dss_pkg::RATE_BITS-1:0] last_rate_reg, last_rate_next;
    logic                          rising_now_reg, rising_now_next;
    logic                          rising_before_reg, rising_before_next;
    logic                          tracking_started_reg, tracking_started_next;
    dss_pkg::kind_t                last_kind_reg, last_kind_next;
    dss_pkg::kind_t                older_kind_reg, older_kind_next;
    logic [dss_pkg::AMP_BITS-1:0]  last_amp_reg, last_amp_next;
    logic [dss_pkg::AMP_BITS-1:0]  older_amp_reg, older_amp_next;
    logic [COUNT_BITS-1:0]         alt_count_reg, alt_count_next;
    logic [COUNT_BITS-1:0]         decay_count_reg, decay_count_next;
    dss_pkg::door_state_t          held_state_reg, held_state_next;

    assign out_free        = !out_valid_reg || result_out.ready;
    assign s1_advance      = in_valid_reg && out_free;
    assign sample_in.ready = !in_valid_reg || out_free;
    assign in_take         = sample_in.valid && sample_in.ready;

    assign result_out.valid      = out_valid_reg;
    assign result_out.door_state = out_state_reg;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        sat_inc = (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
    endfunction

    always_comb
    begin
        logic signed [dss_pkg::PITCH_BITS:0] pitch_wide;
        logic [dss_pkg::PITCH_BITS:0]        pitch_mag;
        logic signed [dss_pkg::RATE_BITS:0]  last_wide;
        logic signed [dss_pkg::RATE_BITS:0]  thr_wide;
        logic signed [dss_pkg::RATE_BITS:0]  neg_last;
        logic                                take;
        dss_pkg::kind_t                      take_kind;
        logic [dss_pkg::AMP_BITS-1:0]        take_amp;

        last_rate_next        = last_rate_reg;
        rising_now_next       = rising_now_reg;
        rising_before_next    = rising_before_reg;
        tracking_started_next = tracking_started_reg;
        last_kind_next        = last_kind_reg;
        older_kind_next       = older_kind_reg;
        last_amp_next         = last_amp_reg;
        older_amp_next        = older_amp_reg;
        alt_count_next        = alt_count_reg;
        decay_count_next      = decay_count_reg;
        held_state_next       = held_state_reg;
        out_state_next        = dss_pkg::ST_NO_SAMPLE;

        pitch_wide = {in_sample_reg.pitch_angle[dss_pkg::PITCH_BITS-1],
                      in_sample_reg.pitch_angle};
        pitch_mag  = pitch_wide[dss_pkg::PITCH_BITS] ? (-pitch_wide) : pitch_wide;
        last_wide  = {last_rate_reg[dss_pkg::RATE_BITS-1], last_rate_reg};
        thr_wide   = $signed({2'b00, extremum_rate_threshold_reg});
        neg_last   = -last_wide;
        take       = 1'b0;
        take_kind  = dss_pkg::KIND_NONE;
        take_amp   = '0;

        if (s1_advance && in_sample_reg.sample_ready)
        begin
            last_rate_next = in_sample_reg.rate_x;
            if (pitch_mag >= {2'b00, open_pitch_limit_reg})
            begin
                tracking_started_next = 1'b0;
                last_kind_next        = dss_pkg::KIND_NONE;
                older_kind_next       = dss_pkg::KIND_NONE;
                last_amp_next         = '0;
                older_amp_next        = '0;
                alt_count_next        = '0;
                decay_count_next      = '0;
                out_state_next        = dss_pkg::ST_OPEN;
            end
            else
            begin
                // equal rates keep the previous direction
                if (last_rate_reg < in_sample_reg.rate_x)
                    rising_now_next = 1'b1;
                else if (last_rate_reg > in_sample_reg.rate_x)
                    rising_now_next = 1'b0;

                if (tracking_started_reg)
                begin
                    if (!rising_now_next && rising_before_reg && (last_wide > thr_wide))
                    begin
                        take      = 1'b1;
                        take_kind = dss_pkg::KIND_PEAK;
                        take_amp  = last_wide[dss_pkg::AMP_BITS-1:0];
                    end
                    else if (rising_now_next && !rising_before_reg
                             && (last_wide <= -thr_wide))
                    begin
                        take      = 1'b1;
                        take_kind = dss_pkg::KIND_TROUGH;
                        // full-scale negative rate saturates
                        take_amp  = neg_last[dss_pkg::AMP_BITS] ? dss_pkg::AMP_MAX
                                    : neg_last[dss_pkg::AMP_BITS-1:0];
                    end

                    if (take)
                    begin
                        if (last_kind_reg == take_kind)
                        begin
                            if (take_amp > last_amp_reg)
                                last_amp_next = take_amp;
                        end
                        else if (last_kind_reg != dss_pkg::KIND_NONE)
                        begin
                            if (older_kind_reg != dss_pkg::KIND_NONE
                                && last_amp_reg <= older_amp_reg)
                                decay_count_next = sat_inc(decay_count_reg);
                            alt_count_next  = sat_inc(alt_count_reg);
                            older_kind_next = last_kind_reg;
                            older_amp_next  = last_amp_reg;
                            last_kind_next  = take_kind;
                            last_amp_next   = take_amp;
                        end
                        else
                        begin
                            last_kind_next = take_kind;
                            last_amp_next  = take_amp;
                        end
                    end

                    // decide only once both sensors are still
                    if (!in_sample_reg.gyro_moving && !in_sample_reg.accel_moving)
                    begin
                        if (decay_count_next >= (alt_count_next >> 1)
                            && pitch_mag < {2'b00, closed_pitch_limit_reg})
                            held_state_next = dss_pkg::ST_CLOSED;
                        else
                            held_state_next = dss_pkg::ST_OPEN;
                    end
                end
                else
                begin
                    tracking_started_next = 1'b1;
                    held_state_next       = dss_pkg::ST_DETECTING;
                end
                rising_before_next = rising_now_next;
                out_state_next     = held_state_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_pitch_limit_reg        <= dss_pkg::OPEN_PITCH_LIMIT_RESET;
            closed_pitch_limit_reg      <= dss_pkg::CLOSED_PITCH_LIMIT_RESET;
            extremum_rate_threshold_reg <= dss_pkg::EXTREMUM_RATE_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dss_pkg::CFG_OPEN_PITCH_LIMIT:        open_pitch_limit_reg        <= cfg_data;
                dss_pkg::CFG_CLOSED_PITCH_LIMIT:      closed_pitch_limit_reg      <= cfg_data;
                dss_pkg::CFG_EXTREMUM_RATE_THRESHOLD: extremum_rate_threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            last_rate_reg        <= '0;
            rising_now_reg       <= 1'b0;
            rising_before_reg    <= 1'b0;
            tracking_started_reg <= 1'b0;
            last_kind_reg        <= dss_pkg::KIND_NONE;
            older_kind_reg       <= dss_pkg::KIND_NONE;
            last_amp_reg         <= '0;
            older_amp_reg        <= '0;
            alt_count_reg        <= '0;
            decay_count_reg      <= '0;
            held_state_reg       <= dss_pkg::ST_DETECTING;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (s1_advance)
                in_valid_reg <= 1'b0;

            if (s1_advance)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;

            last_rate_reg        <= last_rate_next;
            rising_now_reg       <= rising_now_next;
            rising_before_reg    <= rising_before_next;
            tracking_started_reg <= tracking_started_next;
            last_kind_reg        <= last_kind_next;
            older_kind_reg       <= older_kind_next;
            last_amp_reg         <= last_amp_next;
            older_amp_reg        <= older_amp_next;
            alt_count_reg        <= alt_count_next;
            decay_count_reg      <= decay_count_next;
            held_state_reg       <= held_state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_sample_reg.sample_ready <= sample_in.sample_ready;
            in_sample_reg.pitch_angle  <= sample_in.pitch_angle;
            in_sample_reg.rate_x       <= sample_in.rate_x;
            in_sample_reg.gyro_moving  <= sample_in.gyro_moving;
            in_sample_reg.accel_moving <= sample_in.accel_moving;
        end
        if (s1_advance)
            out_state_reg <= out_state_next;
    end

`ifndef SYNTHESIS
    a_decay_le_alt: assert property (@(posedge clk) disable iff (!rst_n)
        decay_count_reg <= alt_count_reg)
        else $error("decay count exceeds alternation count");

    a_cleared_tracking: assert property (@(posedge clk) disable iff (!rst_n)
        !tracking_started_reg |-> (alt_count_reg == '0 && decay_count_reg == '0
                                   && last_kind_reg == dss_pkg::KIND_NONE))
        else $error("tracking state not clear while tracking is off");

    a_older_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        older_kind_reg != dss_pkg::KIND_NONE |-> last_kind_reg != older_kind_reg
                                               && last_kind_reg != dss_pkg::KIND_NONE)
        else $error("older extremum without a differing last extremum");

    a_no_sample_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && !in_sample_reg.sample_ready) |=>
            ($stable(last_rate_reg) && $stable(held_state_reg) && $stable(alt_count_reg)
             && out_state_reg == dss_pkg::ST_NO_SAMPLE))
        else $error("transaction without a sample changed state");
`endif

endmodule
